### design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value table: field widths,
// operation and status codes, and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 32;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // Default table depth.
    localparam int ENTRIES_DEFAULT = 16;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_GET    = 2'd2,
        MODE_SET    = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EXISTS = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_ACCESS,
        S_FINISH
    } state_t;

endpackage

`default_nettype wire

### design/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// Associative table of unique signed keys with one data word per key,
// supporting insert, delete, get and set.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one operation per transaction (mode, key,
//   data_in). The m_ channel returns one result per operation (status,
//   found, data_out), in order. Both channels use valid/ready.
//   Each operation scans every slot of the tag memory, one slot per cycle,
//   through its single read port, then reads and writes back the data
//   memory in the access state and loads the result into the output
//   register in the finish state. A new operation is accepted only after
//   the result of the last one has been loaded into the output register.
//   After reset the table runs a clearing pass that writes every slot's
//   valid bit to zero, one slot per cycle, so s_ready stays low until the
//   pass is over.
//   The result sits in an output register. While it waits for m_ready, the
//   next operation is accepted and scanned; it holds its own result until
//   the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Operation channel.
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kvt_pkg::MODE_W-1:0]    s_mode,
    input  wire logic signed [kvt_pkg::KEY_W-1:0] s_key,
    input  wire logic [kvt_pkg::DATA_W-1:0]    s_data_in,
    // Result channel.
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [kvt_pkg::STATUS_W-1:0]  m_status,
    output logic                               m_found,
    output logic      [kvt_pkg::DATA_W-1:0]    m_data_out
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    kvt_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    // Latched operation.
    kvt_pkg::mode_t              mode_reg;
    logic [kvt_pkg::KEY_W-1:0]   key_reg;
    logic [kvt_pkg::DATA_W-1:0]  data_reg;

    // Scan evaluation stage and search results.
    logic             ev_vld_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Result fields prepared before the output register.
    kvt_pkg::status_t res_status_reg;
    logic             res_found_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [kvt_pkg::STATUS_W-1:0]  m_status_reg;
    logic                          m_found_reg;
    logic [kvt_pkg::DATA_W-1:0]    m_data_out_reg;

    // Memory ports.
    logic                         tag_we;
    logic [IDX_W-1:0]             tag_waddr;
    logic [kvt_pkg::KEY_W:0]      tag_wdata;
    logic [kvt_pkg::KEY_W:0]      tag_q;
    logic                         data_we;
    logic [IDX_W-1:0]             data_waddr;
    logic [kvt_pkg::DATA_W-1:0]   data_q;

    logic s_accept;
    logic out_load;
    logic tag_match;

    kvt_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .aclk       (aclk),
        .tag_we     (tag_we),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .tag_raddr  (cnt_reg),
        .tag_q      (tag_q),
        .data_we    (data_we),
        .data_waddr (data_waddr),
        .data_wdata (data_reg),
        .data_raddr (hit_idx_reg),
        .data_q     (data_q)
    );

    assign s_ready  = (state_reg == kvt_pkg::S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == kvt_pkg::S_FINISH) && (!m_valid_reg || m_ready);

    // A slot matches when it is valid and holds the requested key.
    assign tag_match = tag_q[kvt_pkg::KEY_W] && (tag_q[kvt_pkg::KEY_W-1:0] == key_reg);

    // Next state, counter and memory write controls.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        tag_we     = 1'b0;
        tag_waddr  = cnt_reg;
        tag_wdata  = '0;
        data_we    = 1'b0;
        data_waddr = hit_idx_reg;
        unique case (state_reg)
            kvt_pkg::S_CLEAR: begin
                tag_we = 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = kvt_pkg::S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kvt_pkg::S_IDLE: begin
                cnt_next = '0;
                if (s_accept) begin
                    state_next = kvt_pkg::S_SCAN;
                end
            end
            kvt_pkg::S_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    cnt_next   = '0;
                    state_next = kvt_pkg::S_LAST;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            kvt_pkg::S_LAST: begin
                state_next = kvt_pkg::S_ACCESS;
            end
            kvt_pkg::S_ACCESS: begin
                unique case (mode_reg)
                    kvt_pkg::MODE_INSERT: begin
                        tag_waddr  = free_idx_reg;
                        tag_wdata  = {1'b1, key_reg};
                        data_waddr = free_idx_reg;
                        if (!hit_found_reg && free_found_reg) begin
                            tag_we  = 1'b1;
                            data_we = 1'b1;
                        end
                    end
                    kvt_pkg::MODE_DELETE: begin
                        tag_waddr = hit_idx_reg;
                        tag_wdata = {1'b0, key_reg};
                        tag_we    = hit_found_reg;
                    end
                    kvt_pkg::MODE_GET: begin
                    end
                    kvt_pkg::MODE_SET: begin
                        data_waddr = hit_idx_reg;
                        data_we    = hit_found_reg;
                    end
                    default: begin
                    end
                endcase
                state_next = kvt_pkg::S_FINISH;
            end
            kvt_pkg::S_FINISH: begin
                if (out_load) begin
                    state_next = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kvt_pkg::S_IDLE;
            end
        endcase
    end

    // State and scan counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kvt_pkg::S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Evaluation stage: each scan read is evaluated in the cycle after its address is presented.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_vld_reg <= 1'b0;
        end else begin
            ev_vld_reg <= (state_reg == kvt_pkg::S_SCAN);
        end
        ev_idx_reg <= cnt_reg;
    end

    // Latch the operation on acceptance.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= kvt_pkg::mode_t'(s_mode);
            key_reg  <= $unsigned(s_key);
            data_reg <= s_data_in;
        end
    end

    // Search results: matching slot and lowest free slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (s_accept) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (ev_vld_reg) begin
            if (tag_match) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= ev_idx_reg;
            end
            if (!tag_q[kvt_pkg::KEY_W] && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= ev_idx_reg;
            end
        end
    end

    // Status and found flag are settled once the scan is complete.
    always_ff @(posedge aclk) begin
        if (state_reg == kvt_pkg::S_ACCESS) begin
            res_found_reg <= hit_found_reg;
            priority if (mode_reg == kvt_pkg::MODE_INSERT) begin
                if (hit_found_reg) begin
                    res_status_reg <= kvt_pkg::ST_EXISTS;
                end else if (!free_found_reg) begin
                    res_status_reg <= kvt_pkg::ST_FULL;
                end else begin
                    res_status_reg <= kvt_pkg::ST_OK;
                end
            end else if (hit_found_reg) begin
                res_status_reg <= kvt_pkg::ST_OK;
            end else begin
                res_status_reg <= kvt_pkg::ST_ABSENT;
            end
        end
    end

    // Output register: loaded when free, cleared when the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_status_reg   <= res_status_reg;
            m_found_reg    <= res_found_reg;
            m_data_out_reg <= (mode_reg == kvt_pkg::MODE_GET && res_found_reg) ? data_q : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_found    = m_found_reg;
    assign m_data_out = m_data_out_reg;

endmodule

`default_nettype wire

### design/kvt_store.sv
// ----------------------------------------------------------------------------
// kvt_store
// Entry storage of the key/value table: a tag memory holding a valid bit
// and the key of each slot, and a data memory holding the stored words.
// Both have one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_store #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic                        aclk,
    // Tag memory: {valid, key}.
    input  wire logic                        tag_we,
    input  wire logic [IDX_W-1:0]            tag_waddr,
    input  wire logic [kvt_pkg::KEY_W:0]     tag_wdata,
    input  wire logic [IDX_W-1:0]            tag_raddr,
    output logic      [kvt_pkg::KEY_W:0]     tag_q,
    // Data memory.
    input  wire logic                        data_we,
    input  wire logic [IDX_W-1:0]            data_waddr,
    input  wire logic [kvt_pkg::DATA_W-1:0]  data_wdata,
    input  wire logic [IDX_W-1:0]            data_raddr,
    output logic      [kvt_pkg::DATA_W-1:0]  data_q
);

    logic [kvt_pkg::KEY_W:0]    tag_mem  [ENTRIES];
    logic [kvt_pkg::DATA_W-1:0] data_mem [ENTRIES];

    // Tag memory port, read data registered.
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_q <= tag_mem[tag_raddr];
    end

    // Data memory port, read data registered.
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        data_q <= data_mem[data_raddr];
    end

endmodule

`default_nettype wire

### bench/key_value_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_tb
// Self-checking bench for the key/value table. A short table of directed
// operations covers empty-table misses, duplicate inserts, extreme keys and
// a full table. About 1600 random operations follow, drawn from a small key
// pool so that hits, misses and full-table rejects all recur. Every result
// is checked against the row's own result for typed directed rows, else
// against a bench copy of the table; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module key_value_table_tb;

    localparam int ENTRIES      = 16;
    localparam int RESET_CYCLES = 12;
    localparam int N_DIRECTED   = 26;
    localparam int N_RANDOM     = 1600;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 500;

    // One expected result of the table.
    typedef struct packed {
        kvt_pkg::status_t                status;
        logic                            found;
        logic [kvt_pkg::DATA_W-1:0]      data;
    } kv_result_t;

    // One row of the directed table; typed rows carry their own result.
    typedef struct packed {
        kvt_pkg::mode_t                  op;
        logic [kvt_pkg::KEY_W-1:0]       key;
        logic [kvt_pkg::DATA_W-1:0]      data;
        logic                            typed;
        kv_result_t                      result;
    } stim_row_t;

    // Ready patterns of the result side.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_style_t;

    logic                                aclk       = 1'b0;
    logic                                aresetn    = 1'b0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic [kvt_pkg::MODE_W-1:0]          s_mode     = kvt_pkg::MODE_GET;
    logic signed [kvt_pkg::KEY_W-1:0]    s_key      = '0;
    logic [kvt_pkg::DATA_W-1:0]          s_data_in  = '0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic [kvt_pkg::STATUS_W-1:0]        m_status;
    logic                                m_found;
    logic [kvt_pkg::DATA_W-1:0]          m_data_out;

    // Bench copy of the table contents.
    logic                                tbl_used [ENTRIES];
    logic [kvt_pkg::KEY_W-1:0]           tbl_key  [ENTRIES];
    logic [kvt_pkg::DATA_W-1:0]          tbl_data [ENTRIES];

    kv_result_t                          pending_results [$];
    stim_row_t                           directed_rows [N_DIRECTED];
    logic [kvt_pkg::KEY_W-1:0]           key_pool [POOL_SIZE];

    int                                  error_count  = 0;
    int                                  results_seen = 0;
    int                                  burst_left   = 0;
    int                                  op_count [4];
    int                                  status_count [4];
    logic                                hold_off     = 1'b0;

    key_value_table #(
        .ENTRIES    (ENTRIES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_key      (s_key),
        .s_data_in  (s_data_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_found    (m_found),
        .m_data_out (m_data_out)
    );

    // Clock generation.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("timeout with %0d results still outstanding", pending_results.size());
        $display("key_value_table_tb failed");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Applies one operation to the bench table and returns its result.
    function automatic kv_result_t table_apply(input kvt_pkg::mode_t op,
                                               input logic [kvt_pkg::KEY_W-1:0] k,
                                               input logic [kvt_pkg::DATA_W-1:0] d);
        int         hit_idx;
        int         free_idx;
        kv_result_t r;
        hit_idx  = -1;
        free_idx = -1;
        // Walk downward so that the lowest free slot is the one kept.
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (tbl_used[i] && tbl_key[i] == k) hit_idx = i;
            if (!tbl_used[i]) free_idx = i;
        end
        r.status = kvt_pkg::ST_OK;
        r.found  = (hit_idx >= 0);
        r.data   = '0;
        case (op)
            kvt_pkg::MODE_INSERT: begin
                if (hit_idx >= 0) begin
                    r.status = kvt_pkg::ST_EXISTS;
                end else if (free_idx < 0) begin
                    r.status = kvt_pkg::ST_FULL;
                end else begin
                    tbl_used[free_idx] = 1'b1;
                    tbl_key[free_idx]  = k;
                    tbl_data[free_idx] = d;
                end
            end
            kvt_pkg::MODE_DELETE: begin
                if (hit_idx >= 0) tbl_used[hit_idx] = 1'b0;
                else r.status = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::MODE_GET: begin
                if (hit_idx >= 0) r.data = tbl_data[hit_idx];
                else r.status = kvt_pkg::ST_ABSENT;
            end
            default: begin
                if (hit_idx >= 0) tbl_data[hit_idx] = d;
                else r.status = kvt_pkg::ST_ABSENT;
            end
        endcase
        return r;
    endfunction

    // Draws a key, mostly from the pool; with allow_fresh it may be a fresh or altered key.
    function automatic logic [kvt_pkg::KEY_W-1:0] pick_key(input bit allow_fresh);
        logic [kvt_pkg::KEY_W-1:0] k;
        int                        roll;
        int                        bit_idx;
        k       = key_pool[$urandom_range(POOL_SIZE - 1)];
        roll    = $urandom_range(99);
        bit_idx = $urandom_range(kvt_pkg::KEY_W - 1);
        if (allow_fresh && roll < 8) begin
            k = $urandom;
        end else if (allow_fresh && roll < 15) begin
            k[bit_idx] = ~k[bit_idx];
        end
        return k;
    endfunction

    // Offers one transaction, waits for acceptance and queues its result.
    task automatic offer_op(input kvt_pkg::mode_t op, input logic [kvt_pkg::KEY_W-1:0] k,
                            input logic [kvt_pkg::DATA_W-1:0] d, input logic typed,
                            input kv_result_t typed_result);
        kv_result_t want;
        s_valid   <= 1'b1;
        s_mode    <= op;
        s_key     <= k;
        s_data_in <= d;
        do @(posedge aclk); while (!s_ready);
        want = table_apply(op, k, d);
        if (typed) want = typed_result;
        pending_results.push_back(want);
        op_count[op]++;
    endtask

    // Sender pacing: bursts of back-to-back transactions with gaps between.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(40);
            gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Directed rows: misses on an empty table, duplicates, extremes, full table.
    initial begin
        directed_rows = '{
            '{kvt_pkg::MODE_GET,    32'h0000_0000, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_ABSENT, 1'b0, 32'h0}},
            '{kvt_pkg::MODE_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_ABSENT, 1'b0, 32'h0}},
            '{kvt_pkg::MODE_SET,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{kvt_pkg::ST_ABSENT, 1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_EXISTS, 1'b1, 32'h0}},
            '{kvt_pkg::MODE_GET,    32'h8000_0000, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_OK,     1'b1, 32'hFFFF_FFFF}},
            '{kvt_pkg::MODE_SET,    32'h8000_0000, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_OK,     1'b1, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h0000_0000, 32'h5555_5555, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h0000_0002, 32'h0F0F_0F0F, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h5555_5555, 32'hF0F0_F0F0, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'hAAAA_AAAA, 32'h0000_FFFF, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h0000_FFFF, 32'hFFFF_0000, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'hFFFF_0000, 32'h1234_5678, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h7FFF_FFFE, 32'h8765_4321, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h8000_0001, 32'h0000_0002, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h1234_5678, 32'h0000_0003, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h0101_0101, 32'h0000_0004, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'hFEDC_BA98, 32'h0000_0005, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h3C3C_3C3C, 32'h0000_0006, 1'b1,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h1357_9BDF, 32'h0000_0007, 1'b1,
              '{kvt_pkg::ST_FULL,   1'b0, 32'h0}},
            '{kvt_pkg::MODE_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              '{kvt_pkg::ST_OK,     1'b1, 32'h0}},
            '{kvt_pkg::MODE_INSERT, 32'h1357_9BDF, 32'hC001_D00D, 1'b0,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}},
            '{kvt_pkg::MODE_GET,    32'h1357_9BDF, 32'h0000_0000, 1'b0,
              '{kvt_pkg::ST_OK,     1'b0, 32'h0}}
        };
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
            tbl_data[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            op_count[i]     = 0;
            status_count[i] = 0;
        end
    end

    // Long hold-off on the result side so that the table backs up its input.
    initial begin : sink_hold
        wait (results_seen >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Result side: check each accepted transaction and drive the ready pattern.
    initial begin : result_sink
        kv_result_t  want;
        sink_style_t style;
        int          cyc;
        logic        ready_next;
        style = SINK_OPEN;
        cyc   = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result with no operation pending, status %0d",
                                           m_status));
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_error($sformatf("result %0d status %0d, expected %0d",
                                               results_seen, m_status, want.status));
                    if (m_found !== want.found)
                        report_error($sformatf("result %0d found %0b, expected %0b",
                                               results_seen, m_found, want.found));
                    if (m_data_out !== want.data)
                        report_error($sformatf("result %0d data_out %08h, expected %08h",
                                               results_seen, m_data_out, want.data));
                end
                status_count[m_status]++;
                results_seen++;
            end
            // Switch between randomly chosen stall patterns.
            cyc++;
            if (cyc % 300 == 0) style = sink_style_t'($urandom_range(3));
            case (style)
                SINK_OPEN:   ready_next = 1'b1;
                SINK_COIN:   ready_next = 1'($urandom_range(1));
                SINK_SPARSE: ready_next = ($urandom_range(3) == 0);
                default:     ready_next = ((cyc % 7) < 3);
            endcase
            m_ready <= hold_off ? 1'b0 : ready_next;
        end
    end

    // Operation side: reset, the directed table, then random traffic.
    initial begin : stimulus
        stim_row_t                   row;
        kvt_pkg::mode_t              op;
        logic [kvt_pkg::KEY_W-1:0]   k;
        logic [kvt_pkg::DATA_W-1:0]  d;
        int                          insert_weight;
        int                          roll;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            offer_op(row.op, row.key, row.data, row.typed, row.result);
            pace_sender();
        end

        // Random part; the insert share changes every hundred transactions so
        // that the table alternately fills up and drains.
        insert_weight = 40;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(2))
                    0:       insert_weight = 65;
                    1:       insert_weight = 40;
                    default: insert_weight = 15;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < insert_weight) begin
                op = kvt_pkg::MODE_INSERT;
            end else begin
                case ($urandom_range(2))
                    0:       op = kvt_pkg::MODE_DELETE;
                    1:       op = kvt_pkg::MODE_GET;
                    default: op = kvt_pkg::MODE_SET;
                endcase
            end
            k = pick_key(op != kvt_pkg::MODE_INSERT);
            case ($urandom_range(9))
                0:       d = '0;
                1:       d = '1;
                default: d = $urandom;
            endcase
            offer_op(op, k, d, 1'b0, '0);
            pace_sender();
        end
        s_valid <= 1'b0;

        // Drain, then allow a full operation time for anything stray.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);

        $display("Ran %0d operations: %0d insert, %0d delete, %0d get, %0d set.",
                 op_count[kvt_pkg::MODE_INSERT] + op_count[kvt_pkg::MODE_DELETE]
                 + op_count[kvt_pkg::MODE_GET] + op_count[kvt_pkg::MODE_SET],
                 op_count[kvt_pkg::MODE_INSERT], op_count[kvt_pkg::MODE_DELETE],
                 op_count[kvt_pkg::MODE_GET], op_count[kvt_pkg::MODE_SET]);
        $display("Results seen: %0d ok, %0d duplicate key, %0d missing key, %0d table full.",
                 status_count[kvt_pkg::ST_OK], status_count[kvt_pkg::ST_EXISTS],
                 status_count[kvt_pkg::ST_ABSENT], status_count[kvt_pkg::ST_FULL]);
        if (error_count == 0) begin
            $display("key_value_table_tb passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("key_value_table_tb failed");
        end
        $finish;
    end

endmodule
